FILE: rtl/core/ssd_pkg.sv
// Shared types, constants and control structs of the SCAN disk scheduler.
`timescale 1ns / 1ps

package ssd_pkg;

    localparam int MAX_REQUESTS = 64;
    localparam int TRACK_COUNT  = 200;

    localparam int TRACK_W = 8;
    localparam int DIST_W  = 9;
    localparam int CNT_W   = $clog2(MAX_REQUESTS + 1);
    localparam int HIST_DEPTH = 2 ** TRACK_W;

    localparam logic [TRACK_W-1:0] TRACK_MAX = {TRACK_W{1'b1}};
    // Sweep toward the top track covers (TRACK_COUNT-1-head) + (TRACK_COUNT-1-smallest).
    localparam logic [DIST_W:0] DIST_TOP = (DIST_W + 1)'(2 * (TRACK_COUNT - 1));

    typedef enum logic [0:0] {
        CFG_HEAD_POSITION = 1'b0,
        CFG_MOVE_RIGHT    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic               last_request;
    } t_in_item;

    typedef struct packed {
        logic [TRACK_W-1:0] served_track;
        logic [DIST_W-1:0]  seek_length;
        logic               last_served;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC,
        ST_START,
        ST_RD,
        ST_CHK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clr_wr;    // zero one histogram entry of the power-up pass
        logic load_req;  // capture the incoming request, read its bin
        logic inc;       // write back bin + 1, update count and extremes
        logic start;     // latch distance and count, pick the first group
        logic rd;        // read the bin at the sweep position
        logic chk_load;  // take the bin count just read
        logic emit;      // load one result into the output register
        logic zero_wr;   // clear the bin at the sweep position
        logic advance;   // step the sweep position
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_done;
        logic full;
        logic in_last;
        logic last_req;
        logic rdata_zero;
        logic cnt_one;
        logic rem_one;
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/core/ssd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/ssd_datapath.sv
// Datapath: track histogram, batch statistics, sweep position and output register.
`timescale 1ns / 1ps

module ssd_datapath
    import ssd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl_cmd          i_cmd,
    output t_dp_status         o_status,
    input  t_in_item           i_in_item,
    input  logic               i_cfg_we,
    input  t_cfg_idx           i_cfg_index,
    input  logic [TRACK_W-1:0] i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item
);

    logic [TRACK_W-1:0] r_head;
    logic               r_move_right;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_remaining;
    logic [CNT_W-1:0]   r_cnt;
    logic [TRACK_W-1:0] r_clr_addr;
    logic [TRACK_W-1:0] r_track;
    logic               r_last;
    logic [TRACK_W-1:0] r_min;
    logic [TRACK_W-1:0] r_max;
    logic [DIST_W-1:0]  r_dist;
    logic [TRACK_W-1:0] r_val;
    logic               r_grp_right;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               ram_we;
    logic [TRACK_W-1:0] ram_waddr;
    logic [CNT_W-1:0]   ram_wdata;
    logic [TRACK_W-1:0] ram_raddr;
    logic [CNT_W-1:0]   ram_rdata;

    logic [TRACK_W-1:0] n_min;
    logic [TRACK_W-1:0] n_max;
    logic [DIST_W-1:0]  n_dist;
    logic [DIST_W-1:0]  low_sum;
    logic [TRACK_W-1:0] head_up;

    // Histogram of pending requests: one counter per track value.
    ssd_ram #(
        .WIDTH (CNT_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        ram_we    = i_cmd.clr_wr | i_cmd.inc | i_cmd.zero_wr;
        ram_waddr = r_val;
        ram_wdata = '0;
        if (i_cmd.clr_wr) begin
            ram_waddr = r_clr_addr;
        end else if (i_cmd.inc) begin
            ram_waddr = r_track;
            ram_wdata = ram_rdata + CNT_W'(1);
        end
        ram_raddr = i_cmd.rd ? r_val : i_in_item.track;
    end

    assign head_up = r_head + TRACK_W'(1);

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (r_count == '0 || r_track < r_min) begin
            n_min = r_track;
        end
        if (r_count == '0 || r_track > r_max) begin
            n_max = r_track;
        end
    end

    // Toward zero: head + largest. Toward top: 2*(TRACK_COUNT-1) - head - smallest, floored at 0.
    always_comb begin
        low_sum = {1'b0, r_head} + {1'b0, r_min};
        if (!r_move_right) begin
            n_dist = {1'b0, r_head} + {1'b0, r_max};
        end else if ({1'b0, low_sum} >= DIST_TOP) begin
            n_dist = '0;
        end else begin
            n_dist = DIST_W'(DIST_TOP - {1'b0, low_sum});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_move_right <= 1'b0;
            r_count      <= '0;
            r_remaining  <= '0;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HEAD_POSITION: r_head       <= i_cfg_data;
                    CFG_MOVE_RIGHT:    r_move_right <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + TRACK_W'(1);
            end
            if (i_cmd.inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.start) begin
                r_count <= '0;
            end
            if (i_cmd.start) begin
                r_remaining <= r_count;
            end else if (i_cmd.emit) begin
                r_remaining <= r_remaining - CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_track <= i_in_item.track;
            r_last  <= i_in_item.last_request;
        end
        if (i_cmd.inc) begin
            r_min <= n_min;
            r_max <= n_max;
        end
        if (i_cmd.start) begin
            r_dist <= n_dist;
            // Toward the top with the head on the highest track: nothing lies above.
            if (r_move_right && r_head != TRACK_MAX) begin
                r_grp_right <= 1'b1;
                r_val       <= head_up;
            end else begin
                r_grp_right <= 1'b0;
                r_val       <= r_head;
            end
        end else if (i_cmd.advance) begin
            if (r_grp_right) begin
                if (r_val == TRACK_MAX) begin
                    r_grp_right <= 1'b0;
                    r_val       <= r_head;
                end else begin
                    r_val <= r_val + TRACK_W'(1);
                end
            end else begin
                if (r_val == '0) begin
                    r_grp_right <= 1'b1;
                    r_val       <= head_up;
                end else begin
                    r_val <= r_val - TRACK_W'(1);
                end
            end
        end
        if (i_cmd.chk_load) begin
            r_cnt <= ram_rdata;
        end else if (i_cmd.emit) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_out_item.served_track <= r_val;
            r_out_item.seek_length  <= r_dist;
            r_out_item.last_served  <= (r_remaining == CNT_W'(1));
        end
    end

    always_comb begin
        o_status.clr_done   = (r_clr_addr == TRACK_MAX);
        o_status.full       = (r_count == CNT_W'(MAX_REQUESTS));
        o_status.in_last    = i_in_item.last_request;
        o_status.last_req   = r_last;
        o_status.rdata_zero = (ram_rdata == '0);
        o_status.cnt_one    = (r_cnt == CNT_W'(1));
        o_status.rem_one    = (r_remaining == CNT_W'(1));
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/core/ssd_ctrl.sv
// Controller: power-up clear, request load and sweep sequencing.
`timescale 1ns / 1ps

module ssd_ctrl
    import ssd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (!i_status.full) begin
                        n_state = ST_INC;
                    end else if (i_status.in_last) begin
                        // drop the request but still serve the held batch
                        n_state = ST_START;
                    end
                end
            end
            ST_INC: begin
                n_state = i_status.last_req ? ST_START : ST_IDLE;
            end
            ST_START: n_state = ST_RD;
            ST_RD:    n_state = ST_CHK;
            ST_CHK: begin
                n_state = i_status.rdata_zero ? ST_RD : ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    if (i_status.rem_one) begin
                        n_state = ST_IDLE;
                    end else if (i_status.cnt_one) begin
                        n_state = ST_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_wr = 1'b1;
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_req = i_in_valid;
            end
            ST_INC:   o_cmd.inc   = 1'b1;
            ST_START: o_cmd.start = 1'b1;
            ST_RD:    o_cmd.rd    = 1'b1;
            ST_CHK: begin
                o_cmd.chk_load = !i_status.rdata_zero;
                o_cmd.advance  = i_status.rdata_zero;
            end
            ST_EMIT: begin
                o_cmd.emit    = i_status.out_free;
                // empty the bin on its final result, then move on
                o_cmd.zero_wr = i_status.out_free && i_status.cnt_one;
                o_cmd.advance = i_status.out_free && i_status.cnt_one && !i_status.rem_one;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/scan_disk_scheduler.sv
// Top level of the SCAN (elevator) disk scheduler.
//
//  channel  direction  handshake              payload
//  in       input      i_in_valid/o_in_ready  i_in_item  (track, last_request)
//  out      output     o_out_valid/i_out_ready o_out_item (served_track, seek_length,
//                                                          last_served)
//  cfg      input      i_cfg_we               i_cfg_index, i_cfg_data
//
// Each request is one histogram read and one write back (single RAM port pair);
// a request dropped on a full store is read but not written back.
// After the last request the sweep walks track values from the head outward, reading and
// checking the bin of each value visited and emitting its results, bounded by the output
// handshake. After reset a clearing pass zeroes the 256-entry histogram; no transaction
// is taken on the input during it. A stalled output holds the sweep.
`timescale 1ns / 1ps

module scan_disk_scheduler
    import ssd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               i_cfg_we,
    input  t_cfg_idx           i_cfg_index,
    input  logic [TRACK_W-1:0] i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    ssd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ssd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: tb/sv/tb_scan_disk_scheduler.sv
// Self-checking testbench for the SCAN disk scheduler: sweep-order predictor and handshake drivers.
`timescale 1ns / 1ps

import ssd_pkg::*;

class sweep_scoreboard;
    logic [TRACK_W-1:0] head;
    logic               toward_top;
    logic [TRACK_W-1:0] held_tracks[$];
    t_out_item          due_served[$];
    int                 mismatches;
    int                 served_seen;
    int                 batches;
    int                 dropped;

    function new();
        head        = '0;
        toward_top  = 1'b0;
        mismatches  = 0;
        served_seen = 0;
        batches     = 0;
        dropped     = 0;
    endfunction

    function void set_config(t_cfg_idx idx, logic [TRACK_W-1:0] val);
        case (idx)
            CFG_HEAD_POSITION: head       = val;
            CFG_MOVE_RIGHT:    toward_top = val[0];
            default: ;
        endcase
    endfunction

    function int pending();
        return due_served.size();
    endfunction

    // Store one request; on the last one of a batch, work out the whole sweep.
    function void note_request(t_in_item req);
        int        bin_count[HIST_DEPTH];
        int        order[$];
        int        h;
        int        lo;
        int        hi;
        int        seek_len;
        int        t;
        int        k;
        t_out_item exp_item;

        if (held_tracks.size() < MAX_REQUESTS)
            held_tracks.push_back(req.track);
        else
            dropped++;
        if (!req.last_request)
            return;

        for (t = 0; t < HIST_DEPTH; t++)
            bin_count[t] = 0;
        lo = HIST_DEPTH - 1;
        hi = 0;
        foreach (held_tracks[i]) begin
            bin_count[held_tracks[i]]++;
            if (held_tracks[i] < lo) lo = held_tracks[i];
            if (held_tracks[i] > hi) hi = held_tracks[i];
        end
        h = head;

        // Left group holds tracks at or below the head, right group those above it.
        if (!toward_top) begin
            for (t = h; t >= 0; t--)
                repeat (bin_count[t]) order.push_back(t);
            for (t = h + 1; t < HIST_DEPTH; t++)
                repeat (bin_count[t]) order.push_back(t);
            seek_len = h + hi;
        end else begin
            for (t = h + 1; t < HIST_DEPTH; t++)
                repeat (bin_count[t]) order.push_back(t);
            for (t = h; t >= 0; t--)
                repeat (bin_count[t]) order.push_back(t);
            seek_len = 2 * (TRACK_COUNT - 1) - h - lo;
        end
        if (seek_len < 0)   seek_len = 0;
        if (seek_len > 511) seek_len = 511;

        for (k = 0; k < order.size(); k++) begin
            exp_item.served_track = order[k][TRACK_W-1:0];
            exp_item.seek_length  = seek_len[DIST_W-1:0];
            exp_item.last_served  = (k == order.size() - 1);
            due_served.push_back(exp_item);
        end
        held_tracks.delete();
        batches++;
    endfunction

    function void check_served(t_out_item got);
        t_out_item want;

        served_seen++;
        if (due_served.size() == 0) begin
            $error("unexpected result: served_track %0d seek_length %0d last_served %0d",
                   got.served_track, got.seek_length, got.last_served);
            mismatches++;
            return;
        end
        want = due_served.pop_front();
        if (got.served_track !== want.served_track) begin
            $error("served_track: expected %0d, actual %0d", want.served_track,
                   got.served_track);
            mismatches++;
        end
        if (got.seek_length !== want.seek_length) begin
            $error("seek_length: expected %0d, actual %0d", want.seek_length,
                   got.seek_length);
            mismatches++;
        end
        if (got.last_served !== want.last_served) begin
            $error("last_served: expected %0d, actual %0d", want.last_served,
                   got.last_served);
            mismatches++;
        end
    endfunction
endclass

module tb_scan_disk_scheduler;

    localparam int RANDOM_ITEMS     = 270;
    localparam int SETTLE_CYCLES    = 700;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_AFTER_ITEMS = 120;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in_item;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out_item;
    logic               i_cfg_we;
    t_cfg_idx           i_cfg_index;
    logic [TRACK_W-1:0] i_cfg_data;

    sweep_scoreboard    sb;
    int                 requests_sent;
    int                 settings_used;
    int                 directed_items;
    logic [TRACK_W-1:0] cfg_head;
    bit                 burst_mode;
    bit                 long_hold_done;

    scan_disk_scheduler u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [TRACK_W-1:0] pick_track(logic [TRACK_W-1:0] hd);
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return TRACK_MAX;
            2:       return hd;
            3:       return hd + TRACK_W'(1);
            4, 5:    return TRACK_W'($urandom_range(0, TRACK_COUNT - 1));
            default: return TRACK_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [TRACK_W-1:0] pick_head();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return TRACK_MAX;
            2:       return TRACK_W'(TRACK_COUNT - 1);
            3:       return TRACK_W'($urandom_range(0, 255));
            default: return TRACK_W'($urandom_range(0, TRACK_COUNT - 1));
        endcase
    endfunction

    // Mostly small batches; now and then one that can overflow the store.
    function automatic int pick_batch_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(MAX_REQUESTS - 4, MAX_REQUESTS + 8);
        if (r == 1) return $urandom_range(15, 30);
        return $urandom_range(1, 8);
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [TRACK_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        sb.set_config(idx, val);
        if (idx == CFG_HEAD_POSITION)
            cfg_head = val;
        settings_used++;
    endtask

    task automatic send_request(input logic [TRACK_W-1:0] trk, input logic lst);
        t_in_item req;
        int       gap;
        bit       took;

        req.track        = trk;
        req.last_request = lst;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        // Sample ready mid-cycle; the transaction completes at the next rising edge.
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end
        sb.note_request(req);
        requests_sent++;
    endtask

    task automatic send_batch();
        int                 len;
        logic [TRACK_W-1:0] trk;

        len = pick_batch_len();
        trk = pick_track(cfg_head);
        for (int i = 0; i < len; i++) begin
            if (i == 0 || $urandom_range(0, 9) != 0)
                trk = pick_track(cfg_head);
            send_request(trk, i == len - 1);
        end
    endtask

    // Let the sweep finish, then give the block time to settle.
    task automatic drain_sweep();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            // Start the long hold while a result waits and the sender is still offering.
            if (!long_hold_done && requests_sent >= HOLD_AFTER_ITEMS &&
                o_out_valid && i_in_valid) begin
                long_hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (burst_mode) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_served(o_out_item);
        end
    end

    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_HEAD_POSITION;
        i_cfg_data  <= '0;
        sb             = new();
        requests_sent  = 0;
        settings_used  = 0;
        cfg_head       = '0;
        burst_mode     = 1'b0;
        long_hold_done = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bottom head sweeping down, tracks at both extremes.
        write_reg(CFG_HEAD_POSITION, 8'd0);
        write_reg(CFG_MOVE_RIGHT, 8'd0);
        send_request(8'd0, 1'b0);
        send_request(8'd255, 1'b0);
        send_request(8'd128, 1'b1);
        drain_sweep();

        // Top head sweeping up: right group empty, distance clamps at zero.
        write_reg(CFG_HEAD_POSITION, 8'hFF);
        write_reg(CFG_MOVE_RIGHT, 8'hFF);
        send_request(8'd255, 1'b0);
        send_request(8'd7, 1'b1);
        send_request(8'd255, 1'b1);
        drain_sweep();

        // Both groups, duplicates, a request right at the head.
        write_reg(CFG_HEAD_POSITION, 8'd100);
        write_reg(CFG_MOVE_RIGHT, 8'h01);
        send_request(8'd150, 1'b0);
        send_request(8'd50, 1'b0);
        send_request(8'd100, 1'b0);
        send_request(8'd150, 1'b0);
        send_request(8'd0, 1'b1);
        drain_sweep();

        // Sweeping down with only one group populated; upper data bits ignored.
        write_reg(CFG_MOVE_RIGHT, 8'hFE);
        send_request(8'd180, 1'b0);
        send_request(8'd101, 1'b1);
        send_request(8'd99, 1'b0);
        send_request(8'd100, 1'b0);
        send_request(8'd3, 1'b1);
        drain_sweep();

        // Head on the last valid track, requests straddling it.
        write_reg(CFG_HEAD_POSITION, 8'(TRACK_COUNT - 1));
        send_request(8'd199, 1'b0);
        send_request(8'd200, 1'b0);
        send_request(8'd198, 1'b1);
        drain_sweep();
        directed_items = requests_sent;

        while (requests_sent < directed_items + RANDOM_ITEMS) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            write_reg(CFG_HEAD_POSITION, pick_head());
            write_reg(CFG_MOVE_RIGHT, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(3, 5)) send_batch();
            drain_sweep();
        end
        burst_mode = 1'b0;

        $display("Ran %0d requests in %0d batches (%0d dropped on a full store), %0d results",
                 requests_sent, sb.batches, sb.dropped, sb.served_seen);
        $display("Used %0d register writes across both sweep directions and head extremes",
                 settings_used);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
